/* src/pba_pkg.sv */
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the power-of-two bucket block allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_OOM       = 2'd1;
  localparam logic [1:0] STS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STS_BAD_PTR   = 2'd3;

  // block header and smallest block
  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned MIN_BLOCK    = 8;

  // page size limits and reset value (log2 bytes)
  localparam logic [4:0] PAGE_LOG2_MIN   = 5'd3;
  localparam logic [4:0] PAGE_LOG2_MAX   = 5'd16;
  localparam logic [4:0] PAGE_LOG2_RESET = 5'd12;

  // from this bucket upwards the usable size exceeds any 16-bit request
  localparam int unsigned COPY_CAP_BUCKET = 14;

  // width of the block size walker (holds up to 2^17)
  localparam int unsigned SIZE_W = 18;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ALLOC,
    ST_SIZE,
    ST_CHECK,
    ST_REFILL,
    ST_POP_RD,
    ST_POP_WR,
    ST_LOOKUP,
    ST_LOOK_EVAL,
    ST_FREE_PUSH
  } fsm_state_t;

endpackage

/* src/pow2_bucket_block_allocator.sv */
// ----------------------------------------------------------------------------
// pow2_bucket_block_allocator
// Segregated free-list allocator with power-of-two buckets over a byte pool.
// ----------------------------------------------------------------------------
// One command is taken while busy is low; its single result appears with
// out_valid high for exactly one cycle and cannot be held off. A small
// sequencer drives one link memory and one tag memory, each with a single
// registered read port. After reset the tag memory is swept clear, one
// granule per cycle, while busy is high. A free walks dispatch, pointer
// lookup, tag evaluation and push; an alloc walks dispatch, size search,
// list check, a refill that threads the carved blocks when the list is
// empty, and the pop; realloc adds the lookup and the free push to an alloc.
module pow2_bucket_block_allocator #(
  parameter int unsigned POOL_BYTES_LOG2 = 16,
  parameter int unsigned NUM_BUCKETS     = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_block_address,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_result_address,
  output logic [15:0] out_copy_length,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import pba_pkg::*;

  localparam int unsigned GW   = POOL_BYTES_LOG2 - 3;
  localparam int unsigned GRAN = 1 << GW;
  localparam int unsigned LW   = GW + 1;
  localparam int unsigned BW   = $clog2(NUM_BUCKETS + 1);
  localparam int unsigned HIW  = $clog2(NUM_BUCKETS);
  localparam int unsigned CW   = POOL_BYTES_LOG2 + 1;
  localparam int unsigned AW   = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int unsigned RW   = (POOL_BYTES_LOG2 > 16) ? POOL_BYTES_LOG2 : 16;

  localparam logic [AW-1:0] POOL_A  = AW'(1) << POOL_BYTES_LOG2;
  localparam logic [RW-1:0] GRAN_RW = RW'(GRAN);

  // state and transaction registers
  fsm_state_t      state_r, state_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [15:0]     size_r, size_nxt;
  logic [15:0]     addr_r, addr_nxt;
  logic [SIZE_W-1:0] n_r, n_nxt;
  logic [BW-1:0]   bkt_r, bkt_nxt;
  logic [GW-1:0]   old_g_r, old_g_nxt;
  logic [BW-1:0]   old_b_r, old_b_nxt;
  logic            realloc_r, realloc_nxt;
  logic [CW-1:0]   carve_r, carve_nxt;
  logic [GW:0]     g_r, g_nxt;
  logic [GW:0]     end_g_r, end_g_nxt;
  logic [GW-1:0]   clr_r, clr_nxt;
  logic [4:0]      page_log2_r;
  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [15:0]     res_r, res_nxt;
  logic [15:0]     copy_r, copy_nxt;

  // bucket list heads
  logic [GW-1:0]   head_r [NUM_BUCKETS];
  logic            ne_r   [NUM_BUCKETS];
  logic            head_we;
  logic [GW-1:0]   head_wd;
  logic            ne_we;
  logic            ne_wd;

  // memories
  logic [LW-1:0]   link_mem [GRAN];
  logic [BW-1:0]   tag_mem  [GRAN];
  logic [LW-1:0]   link_rd_r;
  logic [BW-1:0]   tag_rd_r;
  logic            link_we, tag_we;
  logic [GW-1:0]   link_wa, link_ra, tag_wa, tag_ra;
  logic [LW-1:0]   link_wd;
  logic [BW-1:0]   tag_wd;

  // shared datapath terms
  logic [HIW-1:0]  idx;
  logic [GW-1:0]   cur_head;
  logic            cur_ne;
  logic [16:0]     total;
  logic [4:0]      page_c;
  logic [AW-1:0]   page_a, amount, carve_a, carve_sum;
  logic            oom;
  logic [GW:0]     step;
  logic [GW+1:0]   g_adv;
  logic [15:0]     addr_m4;
  logic [RW-1:0]   look_g_rw;
  logic            look_ok;
  logic [RW-1:0]   user_ptr;
  logic [SIZE_W-1:0] prev_usable;
  logic [LW-1:0]   push_link;

  assign idx      = bkt_r[HIW-1:0];
  assign cur_head = head_r[idx];
  assign cur_ne   = ne_r[idx];
  assign total    = {1'b0, size_r} + 17'(HEADER_BYTES);

  // page size clamp and refill amount
  always_comb begin
    if (page_log2_r < PAGE_LOG2_MIN) begin
      page_c = PAGE_LOG2_MIN;
    end else if (page_log2_r > PAGE_LOG2_MAX) begin
      page_c = PAGE_LOG2_MAX;
    end else begin
      page_c = page_log2_r;
    end
  end
  assign page_a    = AW'(1) << page_c;
  assign amount    = (AW'(n_r) <= page_a) ? page_a : AW'(n_r);
  assign carve_a   = AW'(carve_r);
  assign carve_sum = carve_a + amount;
  assign oom       = (carve_a > POOL_A) || (amount > (POOL_A - carve_a));
  assign step      = (GW+1)'(n_r >> 3);
  assign g_adv     = {1'b0, g_r} + {1'b0, step};

  // pointer lookup checks
  assign addr_m4   = addr_r - 16'(HEADER_BYTES);
  assign look_g_rw = RW'(addr_m4 >> 3);
  assign look_ok   = (addr_r >= 16'(HEADER_BYTES)) && (addr_m4[2:0] == 3'd0) &&
                     (look_g_rw < GRAN_RW);

  assign user_ptr    = RW'({cur_head, 3'b000}) + RW'(HEADER_BYTES);
  assign prev_usable = (SIZE_W'(MIN_BLOCK) << old_b_r) - SIZE_W'(HEADER_BYTES);
  assign push_link   = cur_ne ? ({1'b0, cur_head} + LW'(1)) : LW'(0);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    size_nxt      = size_r;
    addr_nxt      = addr_r;
    n_nxt         = n_r;
    bkt_nxt       = bkt_r;
    old_g_nxt     = old_g_r;
    old_b_nxt     = old_b_r;
    realloc_nxt   = realloc_r;
    carve_nxt     = carve_r;
    g_nxt         = g_r;
    end_g_nxt     = end_g_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    res_nxt       = res_r;
    copy_nxt      = copy_r;
    head_we       = 1'b0;
    head_wd       = cur_head;
    ne_we         = 1'b0;
    ne_wd         = 1'b0;
    link_we       = 1'b0;
    link_wa       = g_r[GW-1:0];
    link_wd       = push_link;
    link_ra       = cur_head;
    tag_we        = 1'b0;
    tag_wa        = clr_r;
    tag_wd        = '0;
    tag_ra        = GW'(look_g_rw);
    unique case (state_r)
      ST_CLEAR: begin
        tag_we  = 1'b1;
        clr_nxt = clr_r + GW'(1);
        if (clr_r == GW'(GRAN - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = in_command;
          size_nxt    = in_request_size;
          addr_nxt    = in_block_address;
          res_nxt     = '0;
          copy_nxt    = '0;
          realloc_nxt = 1'b0;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd_r)
          CMD_ALLOC: state_nxt = ST_ALLOC;
          CMD_FREE: begin
            if (addr_r == '0) begin
              status_nxt    = STS_OK;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              state_nxt = ST_LOOKUP;
            end
          end
          CMD_REALLOC: state_nxt = (addr_r == '0) ? ST_ALLOC : ST_LOOKUP;
          default: begin
            status_nxt    = STS_OK;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        endcase
      end
      ST_ALLOC: begin
        if (size_r == '0) begin
          status_nxt    = STS_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          n_nxt     = SIZE_W'(MIN_BLOCK);
          bkt_nxt   = '0;
          state_nxt = ST_SIZE;
        end
      end
      // one doubling per cycle until the block covers request plus header or the last bucket is passed
      ST_SIZE: begin
        if (n_r >= SIZE_W'(total)) begin
          if (bkt_r == BW'(NUM_BUCKETS)) begin
            status_nxt    = STS_TOO_LARGE;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_CHECK;
          end
        end else if (bkt_r == BW'(NUM_BUCKETS)) begin
          status_nxt    = STS_TOO_LARGE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          bkt_nxt = bkt_r + BW'(1);
          n_nxt   = n_r << 1;
        end
      end
      ST_CHECK: begin
        if (cur_ne) begin
          state_nxt = ST_POP_RD;
        end else if (oom) begin
          status_nxt    = STS_OOM;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          g_nxt     = {1'b0, carve_r[POOL_BYTES_LOG2-1:3]};
          end_g_nxt = (GW+1)'(carve_sum >> 3);
          carve_nxt = CW'(carve_sum);
          state_nxt = ST_REFILL;
        end
      end
      // thread one carved block per cycle, ascending
      ST_REFILL: begin
        link_we = 1'b1;
        link_wa = g_r[GW-1:0];
        link_wd = push_link;
        head_we = 1'b1;
        head_wd = g_r[GW-1:0];
        ne_we   = 1'b1;
        ne_wd   = 1'b1;
        g_nxt   = g_adv[GW:0];
        if (g_adv >= {1'b0, end_g_r}) begin
          state_nxt = ST_POP_RD;
        end
      end
      ST_POP_RD: begin
        link_ra   = cur_head;
        state_nxt = ST_POP_WR;
      end
      ST_POP_WR: begin
        if (link_rd_r != '0) begin
          head_we = 1'b1;
          head_wd = GW'(link_rd_r - LW'(1));
        end else begin
          ne_we = 1'b1;
          ne_wd = 1'b0;
        end
        tag_we  = 1'b1;
        tag_wa  = cur_head;
        tag_wd  = bkt_r + BW'(1);
        res_nxt = user_ptr[15:0];
        if (realloc_r) begin
          if (old_b_r >= BW'(COPY_CAP_BUCKET)) begin
            copy_nxt = size_r;
          end else begin
            copy_nxt = (prev_usable < SIZE_W'(size_r)) ? prev_usable[15:0] : size_r;
          end
          bkt_nxt   = old_b_r;
          state_nxt = ST_FREE_PUSH;
        end else begin
          status_nxt    = STS_OK;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOOKUP: begin
        if (look_ok) begin
          tag_ra    = GW'(look_g_rw);
          old_g_nxt = GW'(look_g_rw);
          state_nxt = ST_LOOK_EVAL;
        end else begin
          status_nxt    = STS_BAD_PTR;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LOOK_EVAL: begin
        if (tag_rd_r == '0) begin
          status_nxt    = STS_BAD_PTR;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          old_b_nxt = tag_rd_r - BW'(1);
          if (cmd_r == CMD_FREE || size_r == '0) begin
            bkt_nxt   = tag_rd_r - BW'(1);
            state_nxt = ST_FREE_PUSH;
          end else begin
            realloc_nxt = 1'b1;
            state_nxt   = ST_ALLOC;
          end
        end
      end
      ST_FREE_PUSH: begin
        tag_we        = 1'b1;
        tag_wa        = old_g_r;
        tag_wd        = '0;
        link_we       = 1'b1;
        link_wa       = old_g_r;
        link_wd       = push_link;
        head_we       = 1'b1;
        head_wd       = old_g_r;
        ne_we         = 1'b1;
        ne_wd         = 1'b1;
        status_nxt    = STS_OK;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      carve_r     <= '0;
      out_valid_r <= 1'b0;
      page_log2_r <= PAGE_LOG2_RESET;
      realloc_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      carve_r     <= carve_nxt;
      out_valid_r <= out_valid_nxt;
      realloc_r   <= realloc_nxt;
      if (cfg_we) begin
        page_log2_r <= cfg_wdata;
      end
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    size_r   <= size_nxt;
    addr_r   <= addr_nxt;
    n_r      <= n_nxt;
    bkt_r    <= bkt_nxt;
    old_g_r  <= old_g_nxt;
    old_b_r  <= old_b_nxt;
    g_r      <= g_nxt;
    end_g_r  <= end_g_nxt;
    status_r <= status_nxt;
    res_r    <= res_nxt;
    copy_r   <= copy_nxt;
  end

  // list heads and non-empty flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_BUCKETS; k++) begin
        head_r[k] <= '0;
        ne_r[k]   <= 1'b0;
      end
    end else begin
      if (head_we) begin
        head_r[idx] <= head_wd;
      end
      if (ne_we) begin
        ne_r[idx] <= ne_wd;
      end
    end
  end

  // link memory
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_r <= link_mem[link_ra];
  end

  // tag memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_wa] <= tag_wd;
    end
    tag_rd_r <= tag_mem[tag_ra];
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_address = res_r;
  assign out_copy_length    = copy_r;

  // checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  a_carve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    AW'(carve_r) <= POOL_A)
    else $error("carve pointer beyond pool");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted transaction did not raise busy");

  a_refill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REFILL) |-> (g_r < end_g_r))
    else $error("refill walked past its page");

endmodule

/* dv/pow2_bucket_block_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow2_bucket_block_allocator_tb
// Self-checking bench for the bucket allocator: commands go in through the
// start/busy handshake with random gaps, and a behavioural allocator kept in
// the bench predicts every result. A monitor compares each strobed result
// against the oldest prediction.
// ----------------------------------------------------------------------------
module pow2_bucket_block_allocator_tb;
  import pba_pkg::*;

  localparam int unsigned GRANULES = 8192;
  localparam int unsigned POOL     = 65536;
  localparam int unsigned BUCKETS  = 14;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [15:0] copy;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [15:0] in_request_size;
  logic [15:0] in_block_address;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_result_address;
  logic [15:0] out_copy_length;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;

  // allocator state as the bench predicts it
  logic [12:0] free_head [BUCKETS];
  bit          free_nonempty [BUCKETS];
  logic [13:0] next_link [GRANULES];
  logic [4:0]  owner_tag [GRANULES];
  int unsigned carve_ptr;
  logic [4:0]  page_log2;

  alloc_result_t result_q[$];
  logic [15:0]   live_ptrs[$];
  int unsigned   mismatch_cnt;

  pow2_bucket_block_allocator i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_request_size    (in_request_size),
    .in_block_address   (in_block_address),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_copy_length    (out_copy_length),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // push a block onto its bucket list
  function automatic void push_free(int unsigned g, int unsigned b);
    next_link[g] = free_nonempty[b] ? 14'(free_head[b] + 1) : 14'd0;
    free_head[b] = 13'(g);
    free_nonempty[b] = 1'b1;
  endfunction

  function automatic logic [1:0] alloc_block(int unsigned size, output int unsigned addr);
    int unsigned total, n, i, pl, page, amount, cnt, g, nx;
    addr = 0;
    if (size == 0) return STS_OK;
    total = size + HEADER_BYTES;
    n = MIN_BLOCK;
    i = 0;
    while (n < total) begin
      i++;
      n = n << 1;
    end
    if (i >= BUCKETS) return STS_TOO_LARGE;
    // refill an empty list from the carve pointer
    if (!free_nonempty[i]) begin
      pl = page_log2;
      if (pl < PAGE_LOG2_MIN) pl = PAGE_LOG2_MIN;
      if (pl > PAGE_LOG2_MAX) pl = PAGE_LOG2_MAX;
      page = 1 << pl;
      if (n <= page) begin
        amount = page;
        cnt = page / n;
      end else begin
        amount = n;
        cnt = 1;
      end
      if (carve_ptr > POOL || amount > POOL - carve_ptr) return STS_OOM;
      g = carve_ptr >> 3;
      for (int unsigned k = 0; k < cnt; k++) begin
        push_free(g, i);
        g += n >> 3;
      end
      carve_ptr += amount;
    end
    // pop the head
    g = free_head[i];
    nx = next_link[g];
    if (nx != 0) free_head[i] = 13'(nx - 1);
    else free_nonempty[i] = 1'b0;
    owner_tag[g] = 5'(i + 1);
    addr = (g << 3) + HEADER_BYTES;
    return STS_OK;
  endfunction

  // granule of a live block start, or -1
  function automatic int find_block(int unsigned a);
    int unsigned g;
    if (a < HEADER_BYTES || ((a - HEADER_BYTES) & 7) != 0) return -1;
    g = (a - HEADER_BYTES) >> 3;
    if (g >= GRANULES || owner_tag[g] == 0) return -1;
    return int'(g);
  endfunction

  function automatic logic [1:0] release_block(int unsigned a);
    int g;
    if (a == 0) return STS_OK;
    g = find_block(a);
    if (g < 0) return STS_BAD_PTR;
    push_free(g, owner_tag[g] - 1);
    owner_tag[g] = '0;
    foreach (live_ptrs[j]) begin
      if (live_ptrs[j] == a) begin
        live_ptrs.delete(j);
        break;
      end
    end
    return STS_OK;
  endfunction

  function automatic alloc_result_t predict_command(logic [1:0] cmd, int unsigned size,
                                                     int unsigned a);
    alloc_result_t r;
    int unsigned addr, prev_usable;
    int g;
    r = '0;
    addr = 0;
    case (cmd)
      CMD_ALLOC: r.status = alloc_block(size, addr);
      CMD_FREE: r.status = release_block(a);
      CMD_REALLOC: begin
        if (a == 0) r.status = alloc_block(size, addr);
        else if (size == 0) r.status = release_block(a);
        else begin
          g = find_block(a);
          if (g < 0) r.status = STS_BAD_PTR;
          else begin
            prev_usable = (MIN_BLOCK << (owner_tag[g] - 1)) - HEADER_BYTES;
            r.status = alloc_block(size, addr);
            if (r.status == STS_OK) begin
              r.copy = 16'(prev_usable < size ? prev_usable : size);
              void'(release_block(a));
            end
          end
        end
      end
      default: ;
    endcase
    r.addr = 16'(addr);
    if (addr != 0) live_ptrs.push_back(16'(addr));
    return r;
  endfunction

  // one transaction through the start/busy handshake
  task automatic send_cmd(logic [1:0] cmd, logic [15:0] size, logic [15:0] a);
    int unsigned gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    in_command = cmd;
    in_request_size = size;
    in_block_address = a;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    result_q.push_back(predict_command(cmd, size, a));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    while (result_q.size() != 0 || busy) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_page_log2(logic [4:0] v);
    wait_idle();
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    page_log2 = v;
  endtask

  function automatic logic [15:0] pick_live();
    if (live_ptrs.size() == 0) return 16'(HEADER_BYTES);
    return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
  endfunction

  task automatic test_alloc_free();
    logic [15:0] p;
    send_cmd(CMD_ALLOC, 16'd0, 16'd0);
    send_cmd(CMD_ALLOC, 16'd1, 16'd0);
    send_cmd(CMD_ALLOC, 16'd4, 16'd0);
    send_cmd(CMD_ALLOC, 16'd5, 16'd0);
    send_cmd(CMD_ALLOC, 16'd16380, 16'd0);
    send_cmd(CMD_ALLOC, 16'hFFFF, 16'd0);
    send_cmd(CMD_ALLOC, 16'd65533, 16'd0);
    p = pick_live();
    send_cmd(CMD_FREE, 16'd0, p);
    // double free
    send_cmd(CMD_FREE, 16'd0, p);
    send_cmd(CMD_FREE, 16'd0, 16'd0);
    send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_bad_pointers();
    send_cmd(CMD_FREE, 16'd0, 16'hFFFF);
    send_cmd(CMD_FREE, 16'd0, 16'd3);
    send_cmd(CMD_FREE, 16'd0, 16'd8);
    send_cmd(CMD_REALLOC, 16'd10, 16'h7FFC);
  endtask

  task automatic test_realloc();
    send_cmd(CMD_REALLOC, 16'd20, 16'd0);
    send_cmd(CMD_REALLOC, 16'd100, pick_live());
    send_cmd(CMD_REALLOC, 16'd2, pick_live());
    send_cmd(CMD_REALLOC, 16'hFFFF, pick_live());
    send_cmd(CMD_REALLOC, 16'd0, pick_live());
  endtask

  task automatic test_random_traffic(int unsigned n);
    logic [15:0] size, a;
    int unsigned sel;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: size = 16'($urandom_range(1, 60));
        7, 8: size = 16'($urandom_range(1, 2000));
        default: size = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 9) == 0) a = 16'($urandom_range(0, 65535));
      else if ($urandom_range(0, 19) == 0) a = 16'd0;
      else a = pick_live();
      if (sel < 45) send_cmd(CMD_ALLOC, size, 16'($urandom_range(0, 65535)));
      else if (sel < 78) send_cmd(CMD_FREE, 16'($urandom_range(0, 65535)), a);
      else if (sel < 97) send_cmd(CMD_REALLOC, size, a);
      else send_cmd(CMD_UNUSED, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
    end
  endtask

  task automatic test_pool_exhaustion();
    repeat (20) send_cmd(CMD_ALLOC, 16'($urandom_range(2000, 30000)), 16'd0);
    send_cmd(CMD_ALLOC, 16'd65532, 16'd0);
    while (live_ptrs.size() > 0) send_cmd(CMD_FREE, 16'd0, live_ptrs[0]);
    send_cmd(CMD_ALLOC, 16'd65532, 16'd0);
  endtask

  // result monitor
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid) begin
      if (result_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: status %0d addr %h copy %0d", out_status,
                   out_result_address, out_copy_length);
      end else begin
        exp_r = result_q.pop_front();
        if (exp_r.status !== out_status || exp_r.addr !== out_result_address ||
            exp_r.copy !== out_copy_length) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected status %0d addr %h copy %0d, got %0d %h %0d",
                     exp_r.status, exp_r.addr, exp_r.copy, out_status,
                     out_result_address, out_copy_length);
        end
      end
    end
  end

  // main sequence
  initial begin
    logic [4:0] page_settings [6];
    page_settings = '{5'd3, 5'd16, 5'd0, 5'd31, 5'd7, 5'd12};
    mismatch_cnt = 0;
    carve_ptr = 0;
    page_log2 = PAGE_LOG2_RESET;
    for (int b = 0; b < BUCKETS; b++) begin
      free_head[b] = '0;
      free_nonempty[b] = 1'b0;
    end
    for (int g = 0; g < GRANULES; g++) begin
      next_link[g] = '0;
      owner_tag[g] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_command = CMD_ALLOC;
    in_request_size = '0;
    in_block_address = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_alloc_free();
    test_bad_pointers();
    test_realloc();
    foreach (page_settings[k]) begin
      write_page_log2(page_settings[k]);
      test_random_traffic(240);
    end
    write_page_log2(5'($urandom_range(0, 31)));
    test_random_traffic(240);
    test_pool_exhaustion();

    wait_idle();
    repeat (40) @(posedge clk);
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
src/pba_pkg.sv
src/pow2_bucket_block_allocator.sv
dv/pow2_bucket_block_allocator_tb.sv
